>>> src/iiea_pkg.sv
// iiea_pkg: command, status and control types for the indexed insert/erase array
// shared by iiea_cell and indexed_insert_erase_array; depends on nothing else
package iiea_pkg;

    localparam int CMD_W     = 2;
    localparam int IDX_W     = 5;
    localparam int VAL_W     = 32;
    localparam int CNT_OUT_W = 5;
    localparam int ST_W      = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_ERASE  = 2'd2
    } cmd_t;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [1:0] {
        SH_HOLD,
        SH_INSERT,
        SH_ERASE
    } shift_op_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        shift_op_t        op;
        logic [IDX_W-1:0] idx;
    } cell_ctl_t;

endpackage

>>> src/iiea_cell.sv
// iiea_cell: one element register of the array chain
// takes from its left or right neighbor, or the new word, per iiea_pkg::cell_ctl_t
module iiea_cell #(
    parameter int POS        = 0,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                  aclk,
    input  iiea_pkg::cell_ctl_t   ctl,
    input  logic [ELEM_WIDTH-1:0] ins_value,
    input  logic [ELEM_WIDTH-1:0] left_q,
    input  logic [ELEM_WIDTH-1:0] right_q,
    output logic [ELEM_WIDTH-1:0] q
);
    import iiea_pkg::*;

    logic [ELEM_WIDTH-1:0] elem_reg;
    logic [ELEM_WIDTH-1:0] elem_next;

    always_comb begin
        elem_next = elem_reg;
        case (ctl.op)
            SH_INSERT: begin
                if (POS > int'(ctl.idx)) begin
                    elem_next = left_q;
                end else if (POS == int'(ctl.idx)) begin
                    elem_next = ins_value;
                end
            end
            SH_ERASE: begin
                // everything from the erased place on moves down one
                if (POS >= int'(ctl.idx)) begin
                    elem_next = right_q;
                end
            end
            default: elem_next = elem_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        elem_reg <= elem_next;
    end

    assign q = elem_reg;

endmodule

>>> src/indexed_insert_erase_array.sv
// Ordered store of up to DEPTH elements held in a chain of cells, one element per cell.
// Commands read, insert or erase at an index; every command gives one result word that
// carries the read element (zero unless a good read), the element count after the
// command and a status (ok, index out of range, full on insert). A command is taken
// when s_ready is high and its result appears in the output register on the next cycle:
// one command per cycle sustained unless a low m_ready holds the output register, the
// only stall point, since all cells shift from their neighbors in the same cycle. After
// reset the store is empty and ready at once; an insert at index equal to count appends.
// depends on iiea_pkg and iiea_cell
module indexed_insert_erase_array #(
    parameter int DEPTH      = 16,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [iiea_pkg::CMD_W-1:0]     s_cmd,
    input  logic [iiea_pkg::IDX_W-1:0]     s_index,
    input  logic [iiea_pkg::VAL_W-1:0]     s_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [iiea_pkg::VAL_W-1:0]     m_read_data,
    output logic [iiea_pkg::CNT_OUT_W-1:0] m_count,
    output logic [iiea_pkg::ST_W-1:0]      m_status
);
    import iiea_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  m_valid_reg;
    logic [VAL_W-1:0]      rd_data_reg;
    logic [VAL_W-1:0]      rd_data_next;
    logic [CNT_OUT_W-1:0]  m_count_reg;
    logic [ST_W-1:0]       status_reg;
    logic [ST_W-1:0]       status_next;

    logic                  accept;
    shift_op_t             op_c;
    cell_ctl_t             ctl;
    logic [CMP_W-1:0]      idx_c;
    logic [CMP_W-1:0]      cnt_c;
    logic [AW-1:0]         addr;
    logic [ELEM_WIDTH-1:0] ins_value;
    logic [ELEM_WIDTH-1:0] elem [DEPTH];

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign idx_c     = CMP_W'(s_index);
    assign cnt_c     = CMP_W'(count_reg);
    assign addr      = AW'(s_index);
    assign ins_value = ELEM_WIDTH'(s_value);

    always_comb begin
        op_c         = SH_HOLD;
        count_next   = count_reg;
        rd_data_next = '0;
        status_next  = ST_OK;
        case (s_cmd)
            CMD_READ: begin
                if (idx_c < cnt_c) begin
                    rd_data_next = VAL_W'(elem[addr]);
                end else begin
                    status_next = ST_RANGE;
                end
            end
            CMD_INSERT: begin
                if (count_reg == CNT_W'(DEPTH)) begin
                    status_next = ST_FULL;
                end else if (idx_c > cnt_c) begin
                    status_next = ST_RANGE;
                end else begin
                    op_c       = SH_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_ERASE: begin
                if (idx_c < cnt_c) begin
                    op_c       = SH_ERASE;
                    count_next = count_reg - 1'b1;
                end else begin
                    status_next = ST_RANGE;
                end
            end
            default: status_next = ST_RANGE;
        endcase
    end

    assign ctl.op  = accept ? op_c : SH_HOLD;
    assign ctl.idx = s_index;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        // ends loop to themselves; cell 0 never takes left_q, the last holds on erase
        iiea_cell #(
            .POS        (k),
            .ELEM_WIDTH (ELEM_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .ins_value (ins_value),
            .left_q    (elem[(k > 0) ? k - 1 : k]),
            .right_q   (elem[(k < DEPTH - 1) ? k + 1 : k]),
            .q         (elem[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= rd_data_next;
            m_count_reg <= CNT_OUT_W'(count_next);
            status_reg  <= status_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = rd_data_reg;
    assign m_count     = m_count_reg;
    assign m_status    = status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count above capacity");

    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(count_reg))
        else $error("count moved without a command");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && ctl.op == SH_INSERT |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the count");

    a_result_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_count_reg == CNT_OUT_W'(count_reg))
        else $error("result count differs from stored count");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && status_reg == ST_FULL |-> count_reg == CNT_W'(DEPTH))
        else $error("full status while not full");
`endif

endmodule
